@@ hdl/bps_pkg.sv @@
`timescale 1ns / 1ps
// bps_pkg: shared types and constants of the byte pattern scanner
// no dependencies; imported by the interfaces and every module of the block
package bps_pkg;

   localparam int BYTE_W            = 8;
   localparam int ADDR_W            = 64;
   localparam int LENGTH_W          = 6;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 64;
   localparam int PATTERN_WORDS     = 4;
   localparam int PATTERN_REG_BYTES = 32;
   localparam int BYTES_PER_WORD    = 8;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_0_7    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_8_15   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_16_23  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_24_31  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_BASE    = 3'd5;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic     found;
      addr_type match_address;
   } result_type;

   // one result word handed from the scan logic to the output buffer
   typedef struct packed {
      logic       push;
      result_type word;
   } rsp_push_type;

endpackage

@@ hdl/bps_channels.sv @@
`timescale 1ns / 1ps
// bps_req_if and bps_rsp_if: valid/ready channels of the byte pattern scanner
// depends on bps_pkg for the payload types
interface bps_req_if;
   import bps_pkg::*;
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface bps_rsp_if;
   import bps_pkg::*;
   logic     valid;
   logic     ready;
   logic     found;
   addr_type match_address;

   modport source (output valid, output found, output match_address, input ready);
   modport sink (input valid, input found, input match_address, output ready);
endinterface

@@ hdl/byte_pattern_scanner.sv @@
`timescale 1ns / 1ps
// byte_pattern_scanner: top level, first exact match of a byte pattern in a byte stream
// depends on bps_pkg, bps_channels, bps_cell and bps_rsp_buf
//
//   channel   direction  handshake         word contents
//   req_port  in         valid / ready     data_byte, final_byte
//   rsp_port  out        valid / ready     found, match_address
//   csr_*     in         csr_wr_en only    csr_index, csr_wdata (no read-back)
//
// one byte is taken every cycle while req_port.ready is high; the window compare
// is combinational across the cells, and the result lands in a two-word output buffer
// req_port.ready drops only while that buffer holds two unclaimed words
// reset (synchronous, active high) clears the registers to their defaults
// (length 1, pattern and base zero), the region state and the buffer
module byte_pattern_scanner #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   bps_req_if.sink                             req_port,
   bps_rsp_if.source                           rsp_port,
   input  logic                                csr_wr_en,
   input  logic [bps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bps_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bps_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   // configuration registers
   logic [LENGTH_W-1:0] length_ff;
   logic [63:0]         pattern_words_ff [PATTERN_WORDS];
   addr_type            region_base_ff;

   // region state
   addr_type            seen_ff, seen_in;
   logic [LEN_W-1:0]    fill_ff, fill_in;
   logic                matched_ff, matched_in;

   logic [LEN_W-1:0]    len_eff;
   logic [LEN_W-1:0]    fill_next;
   logic [MAX_PATTERN-1:0][BYTE_W-1:0] pattern_vec;
   logic [MAX_PATTERN-1:0][BYTE_W-1:0] window;
   logic [MAX_PATTERN-1:0]             cell_eq;
   logic                accept;
   logic                hit;
   logic                emit_found;
   logic                emit_none;
   logic                buf_full;
   addr_type            match_addr;
   rsp_push_type        push_req;

   // ---------------- configuration port ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff      <= LENGTH_W'(1);
         region_base_ff <= '0;
         for (int w = 0; w < PATTERN_WORDS; w++) begin
            pattern_words_ff[w] <= '0;
         end
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: length_ff           <= csr_wdata[LENGTH_W-1:0];
            CSR_PATTERN_0_7:    pattern_words_ff[0] <= csr_wdata;
            CSR_PATTERN_8_15:   pattern_words_ff[1] <= csr_wdata;
            CSR_PATTERN_16_23:  pattern_words_ff[2] <= csr_wdata;
            CSR_PATTERN_24_31:  pattern_words_ff[3] <= csr_wdata;
            CSR_REGION_BASE:    region_base_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // lengths above the window size are clipped to it
   always_comb begin
      if (int'(length_ff) > MAX_PATTERN) begin
         len_eff = LEN_W'(MAX_PATTERN);
      end else begin
         len_eff = LEN_W'(length_ff);
      end
   end

   // pattern bytes past the four pattern registers read as zero
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
      if (k < PATTERN_REG_BYTES) begin : g_reg
         assign pattern_vec[k] =
            pattern_words_ff[k / BYTES_PER_WORD][(k % BYTES_PER_WORD)*BYTE_W +: BYTE_W];
      end else begin : g_zero
         assign pattern_vec[k] = '0;
      end
   end

   // ---------------- row of window cells ----------------
   // cell 0 takes the incoming byte, each later cell takes its neighbour's
   assign accept = req_port.valid && req_port.ready;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      byte_type prev_byte;
      if (i == 0) begin : g_head
         assign prev_byte = req_port.data_byte;
      end else begin : g_link
         assign prev_byte = window[i-1];
      end
      bps_cell #(
         .MAX_PATTERN (MAX_PATTERN),
         .INDEX       (i)
      ) u_cell (
         .clock       (clock),
         .shift_en    (accept),
         .prev_byte   (prev_byte),
         .len_eff     (len_eff),
         .pattern_vec (pattern_vec),
         .byte_out    (window[i]),
         .eq          (cell_eq[i])
      );
   end

   // ---------------- match decision ----------------
   // fill counts region bytes up to the window size, enough for the length test
   assign fill_next = (fill_ff == LEN_W'(MAX_PATTERN)) ? fill_ff : fill_ff + LEN_W'(1);

   assign hit = (len_eff != '0) && (fill_next >= len_eff) && (&cell_eq);

   assign emit_found = hit && !matched_ff;
   // a region that ends without any match reports not found once
   assign emit_none  = req_port.final_byte && !matched_ff && !hit;

   // first byte of the match: base + bytes seen including this one - length
   assign match_addr = region_base_ff + seen_ff + ADDR_W'(1) - ADDR_W'(len_eff);

   always_comb begin
      seen_in    = seen_ff;
      fill_in    = fill_ff;
      matched_in = matched_ff;
      if (accept) begin
         if (req_port.final_byte) begin
            seen_in    = '0;
            fill_in    = '0;
            matched_in = 1'b0;
         end else begin
            seen_in    = seen_ff + ADDR_W'(1);
            fill_in    = fill_next;
            matched_in = matched_ff || hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         fill_ff    <= '0;
         matched_ff <= 1'b0;
      end else begin
         seen_ff    <= seen_in;
         fill_ff    <= fill_in;
         matched_ff <= matched_in;
      end
   end

   // ---------------- output buffer ----------------
   always_comb begin
      push_req.push               = accept && (emit_found || emit_none);
      push_req.word.found         = emit_found;
      push_req.word.match_address = emit_found ? match_addr : '0;
   end

   bps_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .push_req (push_req),
      .full     (buf_full),
      .rsp      (rsp_port)
   );

   assign req_port.ready = !buf_full;

   // ---------------- assertions ----------------
   // a region closes with its state cleared
   a_region_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_port.final_byte |=> !matched_ff && seen_ff == '0 && fill_ff == '0)
      else $error("region state not cleared after final byte");

   // nothing is reported once a match has been reported in the region
   a_silent_after_match: assert property (@(posedge clock) disable iff (reset)
      accept && matched_ff |-> !push_req.push)
      else $error("result pushed after the region already matched");

   // a found word mid-region marks the region as matched
   a_found_marks: assert property (@(posedge clock) disable iff (reset)
      push_req.push && push_req.word.found && !req_port.final_byte |=> matched_ff)
      else $error("found result without the matched flag following");

   // fill never passes the window size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LEN_W'(MAX_PATTERN))
      else $error("fill count beyond window size");

   // the output buffer is never pushed while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      buf_full |-> !push_req.push)
      else $error("result pushed into a full output buffer");

endmodule

@@ hdl/bps_cell.sv @@
`timescale 1ns / 1ps
// bps_cell: one window position, holds a byte and compares it to its pattern byte
// depends on bps_pkg; instantiated in a row by byte_pattern_scanner
module bps_cell #(
   parameter int MAX_PATTERN = 32,
   parameter int INDEX       = 0,
   localparam int LEN_W      = $clog2(MAX_PATTERN + 1)
) (
   input  logic                                   clock,
   input  logic                                   shift_en,
   input  bps_pkg::byte_type                      prev_byte,
   input  logic [LEN_W-1:0]                       len_eff,
   input  logic [MAX_PATTERN-1:0][bps_pkg::BYTE_W-1:0] pattern_vec,
   output bps_pkg::byte_type                      byte_out,
   output logic                                   eq
);
   import bps_pkg::*;

   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   byte_type         byte_ff;
   byte_type         byte_in;
   logic             active;
   logic [LEN_W-1:0] sel;

   assign byte_in  = shift_en ? prev_byte : byte_ff;
   assign byte_out = byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // this cell faces pattern byte len - 1 - index; compare the byte shifted in
   assign active = len_eff > LEN_W'(INDEX);
   assign sel    = len_eff - LEN_W'(INDEX) - LEN_W'(1);
   assign eq     = !active || (prev_byte == pattern_vec[sel[IDX_W-1:0]]);

endmodule

@@ hdl/bps_rsp_buf.sv @@
`timescale 1ns / 1ps
// bps_rsp_buf: two-word output buffer that drives the result channel
// depends on bps_pkg and bps_rsp_if
module bps_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  bps_pkg::rsp_push_type push_req,
   output logic                  full,
   bps_rsp_if.source             rsp
);
   import bps_pkg::*;

   logic [1:0] count_ff, count_in;
   logic [1:0] wr_slot;
   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic       pop;

   assign pop     = (count_ff != 2'd0) && rsp.ready;
   assign wr_slot = count_ff - {1'b0, pop};

   always_comb begin
      count_in = count_ff - {1'b0, pop} + {1'b0, push_req.push};
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (push_req.push && wr_slot == 2'd0) begin
         slot0_in = push_req.word;
      end
      if (push_req.push && wr_slot == 2'd1) begin
         slot1_in = push_req.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign full              = count_ff == 2'd2;
   assign rsp.valid         = count_ff != 2'd0;
   assign rsp.found         = slot0_ff.found;
   assign rsp.match_address = slot0_ff.match_address;

endmodule
